### src/p1unpad_pkg.sv
// shared types and constants for the pkcs#1 v1.5 unpad checker
// no dependencies; used by pkcs1v15_unpad_checker
`default_nettype none

package p1unpad_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 512;
  localparam int unsigned LEN_W           = 10;
  localparam int unsigned MIN_BLOCK       = 11;
  localparam int unsigned MIN_PAD         = 8;

  // block type codes
  localparam logic [1:0] PT_VERIFY  = 2'd1;
  localparam logic [1:0] PT_DECRYPT = 2'd2;

  // header, padding and separator byte values
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_BAD_PAD   = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // register indexes
  localparam logic [1:0] REG_PADDING_TYPE = 2'd0;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
  localparam logic [1:0] REG_TAIL_LIMIT   = 2'd2;

  // reset values of the registers
  localparam logic [1:0]       RST_PADDING_TYPE = PT_DECRYPT;
  localparam logic [LEN_W-1:0] RST_BLOCK_LENGTH = 10'd256;
  localparam logic [LEN_W-1:0] RST_TAIL_LIMIT   = 10'd256;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

`default_nettype wire

### src/pkcs1v15_unpad_checker.sv
// streaming pkcs#1 v1.5 padding checker, top level
// depends on p1unpad_pkg (result type, codes, limits)
`default_nettype none

// Takes the decrypted RSA block one byte per beat, most significant first,
// and checks 00 || BT || PS || 00 || T. For block type 1 the padding must be
// all FF up to a separator fixed by block_length - tail_limit - 1, and the
// tail must equal expect_byte beat for beat. For block type 2 the padding runs
// to the first zero byte and every later byte goes out as a data beat, unless
// the message exceeds tail_limit, in which case the data is withheld and
// status 3 is given. The last byte of a block is followed by one status beat
// (last = 1) carrying the status and the message length; data beats of a bad
// block still go out and must be dropped unless the status is ok.
// Rate: one input byte per clock. Each byte is checked combinationally by
// a few compares against the running state, and its one or two results go
// into a four-entry output queue; in_ready is high while the queue has room
// for two beats, so with out_ready held high the block never stalls, and
// results are registered in the queue before they go out.
// Any register write restarts the current block. With bad parameters
// (type not 1 or 2, length outside 11..512, or type 1 with length below
// 11 + tail_limit) every byte yields a status-1 beat on its own.
module pkcs1v15_unpad_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input byte channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_block_byte,
  input  wire logic [7:0]                    in_expect_byte,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_result_kind,
  output logic [7:0]                         out_data_byte,
  output logic [1:0]                         out_status,
  output logic [p1unpad_pkg::LEN_W-1:0]      out_message_length,
  output logic                               out_last,
  // apb-style configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned LW = p1unpad_pkg::LEN_W;

  // configuration registers
  logic [1:0]    padding_type_r;
  logic [LW-1:0] block_length_r;
  logic [LW-1:0] tail_limit_r;

  // per-block running state
  logic [LW-1:0] byte_position_r,      byte_position_nxt;
  logic          header_ok_r,          header_ok_nxt;
  logic          pad_ok_r,             pad_ok_nxt;
  logic          tail_ok_r,            tail_ok_nxt;
  logic          separator_seen_r,     separator_seen_nxt;
  logic [LW-1:0] separator_position_r, separator_position_nxt;
  logic          too_small_r,          too_small_nxt;

  // output queue
  p1unpad_pkg::result_t q_mem_r [4];
  logic [1:0] q_wp_r;
  logic [1:0] q_rp_r;
  logic [2:0] q_cnt_r;

  logic in_acc;
  logic out_acc;
  logic cfg_wr;
  logic [1:0] cfg_idx;

  // results of the current byte
  logic                 emit_data;
  logic                 emit_status;
  p1unpad_pkg::result_t data_res;
  p1unpad_pkg::result_t status_res;
  logic [1:0]           push_cnt;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (q_cnt_r <= 3'd2);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (q_cnt_r != 3'd0);
  assign out_acc  = out_valid && out_ready;

  // register read-back
  always_comb begin
    prdata = 32'd0;
    case (cfg_idx)
      p1unpad_pkg::REG_PADDING_TYPE: prdata = {30'd0, padding_type_r};
      p1unpad_pkg::REG_BLOCK_LENGTH: prdata = {22'd0, block_length_r};
      p1unpad_pkg::REG_TAIL_LIMIT:   prdata = {22'd0, tail_limit_r};
      default:                       prdata = 32'd0;
    endcase
  end

  // byte check: one pass over the current byte and the running state
  always_comb begin
    logic          params_ok;
    logic          is_verify;
    logic [LW:0]   min_len_v;
    logic [LW-1:0] sep_pos;
    logic [LW-1:0] remain;
    logic [LW-1:0] pos_m2;
    logic          last_byte;
    logic [1:0]    st;
    logic [LW-1:0] mlen;

    is_verify = (padding_type_r == p1unpad_pkg::PT_VERIFY);
    min_len_v = {1'b0, tail_limit_r} + (LW+1)'(p1unpad_pkg::MIN_BLOCK);
    params_ok = (is_verify || padding_type_r == p1unpad_pkg::PT_DECRYPT)
             && (block_length_r >= LW'(p1unpad_pkg::MIN_BLOCK))
             && (block_length_r <= LW'(p1unpad_pkg::MAX_BLOCK_BYTES))
             && !(is_verify && ({1'b0, block_length_r} < min_len_v));
    sep_pos   = block_length_r - tail_limit_r - LW'(1);
    remain    = block_length_r - LW'(1) - byte_position_r;
    pos_m2    = byte_position_r - LW'(2);
    last_byte = ({1'b0, byte_position_r} + (LW+1)'(1)) >= {1'b0, block_length_r};

    header_ok_nxt          = header_ok_r;
    pad_ok_nxt             = pad_ok_r;
    tail_ok_nxt            = tail_ok_r;
    separator_seen_nxt     = separator_seen_r;
    separator_position_nxt = separator_position_r;
    too_small_nxt          = too_small_r;
    byte_position_nxt      = byte_position_r + LW'(1);
    emit_data              = 1'b0;
    emit_status            = 1'b0;
    st                     = p1unpad_pkg::ST_OK;
    mlen                   = '0;

    data_res.kind   = p1unpad_pkg::KIND_DATA;
    data_res.data   = in_block_byte;
    data_res.status = p1unpad_pkg::ST_OK;
    data_res.length = '0;

    if (!params_ok) begin
      emit_status = 1'b1;
      st          = p1unpad_pkg::ST_INVALID;
      mlen        = '0;
    end else begin
      if (byte_position_r == LW'(0)) begin
        if (in_block_byte != p1unpad_pkg::BYTE_ZERO) header_ok_nxt = 1'b0;
      end else if (byte_position_r == LW'(1)) begin
        if (in_block_byte != {6'd0, padding_type_r}) header_ok_nxt = 1'b0;
      end else if (is_verify) begin
        if (byte_position_r < sep_pos) begin
          if (in_block_byte != p1unpad_pkg::BYTE_FF) pad_ok_nxt = 1'b0;
        end else if (byte_position_r == sep_pos) begin
          if (in_block_byte != p1unpad_pkg::BYTE_ZERO) pad_ok_nxt = 1'b0;
          separator_seen_nxt     = 1'b1;
          separator_position_nxt = byte_position_r;
        end else begin
          if (in_block_byte != in_expect_byte) tail_ok_nxt = 1'b0;
        end
      end else begin
        if (!separator_seen_r) begin
          if (in_block_byte == p1unpad_pkg::BYTE_ZERO) begin
            separator_seen_nxt     = 1'b1;
            separator_position_nxt = byte_position_r;
            if (pos_m2 < LW'(p1unpad_pkg::MIN_PAD)) pad_ok_nxt = 1'b0;
            too_small_nxt = (remain > tail_limit_r);
          end
        end else if (!too_small_r) begin
          emit_data = 1'b1;
        end
      end

      if (last_byte) begin
        emit_status = 1'b1;
        if (is_verify) begin
          mlen = tail_limit_r;
          st   = (header_ok_nxt && pad_ok_nxt && tail_ok_nxt) ?
                 p1unpad_pkg::ST_OK : p1unpad_pkg::ST_BAD_PAD;
        end else if (!separator_seen_nxt) begin
          mlen = '0;
          st   = p1unpad_pkg::ST_INVALID;
        end else begin
          mlen = block_length_r - LW'(1) - separator_position_nxt;
          if (too_small_nxt) st = p1unpad_pkg::ST_TOO_SMALL;
          else st = (header_ok_nxt && pad_ok_nxt) ?
                    p1unpad_pkg::ST_OK : p1unpad_pkg::ST_BAD_PAD;
        end
      end
    end

    status_res.kind   = p1unpad_pkg::KIND_STATUS;
    status_res.data   = 8'd0;
    status_res.status = st;
    status_res.length = mlen;

    push_cnt = in_acc ? ({1'b0, emit_data} + {1'b0, emit_status}) : 2'd0;
  end

  // configuration registers and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      padding_type_r       <= p1unpad_pkg::RST_PADDING_TYPE;
      block_length_r       <= p1unpad_pkg::RST_BLOCK_LENGTH;
      tail_limit_r         <= p1unpad_pkg::RST_TAIL_LIMIT;
      byte_position_r      <= '0;
      header_ok_r          <= 1'b1;
      pad_ok_r             <= 1'b1;
      tail_ok_r            <= 1'b1;
      separator_seen_r     <= 1'b0;
      separator_position_r <= '0;
      too_small_r          <= 1'b0;
    end else if (cfg_wr && (cfg_idx inside {p1unpad_pkg::REG_PADDING_TYPE,
                                            p1unpad_pkg::REG_BLOCK_LENGTH,
                                            p1unpad_pkg::REG_TAIL_LIMIT})) begin
      // any register write restarts the block
      case (cfg_idx)
        p1unpad_pkg::REG_PADDING_TYPE: padding_type_r <= pwdata[1:0];
        p1unpad_pkg::REG_BLOCK_LENGTH: block_length_r <= pwdata[LW-1:0];
        p1unpad_pkg::REG_TAIL_LIMIT:   tail_limit_r   <= pwdata[LW-1:0];
        default:                       ;
      endcase
      byte_position_r      <= '0;
      header_ok_r          <= 1'b1;
      pad_ok_r             <= 1'b1;
      tail_ok_r            <= 1'b1;
      separator_seen_r     <= 1'b0;
      separator_position_r <= '0;
      too_small_r          <= 1'b0;
    end else if (in_acc) begin
      if (emit_status) begin
        // end of block or bad parameters: back to the start
        byte_position_r      <= '0;
        header_ok_r          <= 1'b1;
        pad_ok_r             <= 1'b1;
        tail_ok_r            <= 1'b1;
        separator_seen_r     <= 1'b0;
        separator_position_r <= '0;
        too_small_r          <= 1'b0;
      end else begin
        byte_position_r      <= byte_position_nxt;
        header_ok_r          <= header_ok_nxt;
        pad_ok_r             <= pad_ok_nxt;
        tail_ok_r            <= tail_ok_nxt;
        separator_seen_r     <= separator_seen_nxt;
        separator_position_r <= separator_position_nxt;
        too_small_r          <= too_small_nxt;
      end
    end
  end

  // output queue: up to two beats in, one beat out per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wp_r  <= q_wp_r + push_cnt;
      q_rp_r  <= q_rp_r + {1'b0, out_acc};
      q_cnt_r <= q_cnt_r + {1'b0, push_cnt} - {2'b0, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (emit_data) begin
        q_mem_r[q_wp_r] <= data_res;
        if (emit_status) q_mem_r[q_wp_r + 2'd1] <= status_res;
      end else if (emit_status) begin
        q_mem_r[q_wp_r] <= status_res;
      end
    end
  end

  assign out_result_kind    = q_mem_r[q_rp_r].kind;
  assign out_data_byte      = q_mem_r[q_rp_r].data;
  assign out_status         = q_mem_r[q_rp_r].status;
  assign out_message_length = q_mem_r[q_rp_r].length;
  assign out_last           = q_mem_r[q_rp_r].kind;

endmodule

`default_nettype wire
